// ===== rtl/signed_distance_primitive_macros.svh =====
// Assertion macros shared by the signed distance primitive RTL.
`ifndef SIGNED_DISTANCE_PRIMITIVE_MACROS_SVH
`define SIGNED_DISTANCE_PRIMITIVE_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SDP_ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("sdp assertion failed");

// Next-cycle implication, disabled during reset.
`define SDP_ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("sdp assertion failed");

`endif

// ===== rtl/sdp_pkg.sv =====
// Types, constants and helper functions of the signed distance primitive.
`default_nettype none

package sdp_pkg;

    localparam int COORD_WIDTH = 32;
    localparam int COORD_W     = (COORD_WIDTH > 32) ? 32 : COORD_WIDTH;

    localparam int DW    = 33;
    localparam int EW    = 49;
    localparam int SW    = 51;
    localparam int S16W  = 37;
    localparam int TW    = 53;
    localparam int XW    = 55;
    localparam int QW    = 40;
    localparam int HALFW = 20;
    localparam int PRW   = 69;
    localparam int RADW  = 82;
    localparam int ROOTW = 41;
    localparam int REMW  = ROOTW + 3;
    localparam int SUBW  = 56;
    localparam int DISTW = 57;
    localparam int PRODW = 65;
    localparam int PADDRW = 6;

    localparam logic [1:0] MODE_SPHERE   = 2'd0;
    localparam logic [1:0] MODE_CYLINDER = 2'd1;
    localparam logic [1:0] MODE_CONE     = 2'd2;
    localparam logic [1:0] MODE_PLANE    = 2'd3;

    localparam logic [2:0] REG_SHAPE_MODE  = 3'd0;
    localparam logic [2:0] REG_CENTER_X    = 3'd1;
    localparam logic [2:0] REG_CENTER_Y    = 3'd2;
    localparam logic [2:0] REG_CENTER_Z    = 3'd3;
    localparam logic [2:0] REG_AXIS_PACKED = 3'd4;
    localparam logic [2:0] REG_SHAPE_PARAM = 3'd5;
    localparam logic [2:0] REG_NORM_FACTOR = 3'd6;

    typedef struct packed {
        logic signed [31:0] pos_x;
        logic signed [31:0] pos_y;
        logic signed [31:0] pos_z;
    } t_in_item;

    typedef struct packed {
        logic signed [31:0] distance;
        logic               saturated;
    } t_out_item;

    typedef struct packed {
        logic en;
        logic vld;
    } t_pipe_ctl;

    function automatic logic signed [31:0] coord_ext(input logic [31:0] v);
        logic signed [COORD_W-1:0] t;
        t = v[COORD_W-1:0];
        return 32'(t);
    endfunction

    function automatic logic signed [S16W-1:0] shr14_s(input logic signed [SW-1:0] v);
        logic [SW-1:0] m;
        m = v[SW-1] ? SW'(-v) : SW'(v);
        m = m >> 14;
        return v[SW-1] ? -S16W'(m) : S16W'(m);
    endfunction

    function automatic logic signed [QW-1:0] shr14_x(input logic signed [XW-1:0] v);
        logic [XW-1:0] m;
        m = v[XW-1] ? XW'(-v) : XW'(v);
        m = m >> 14;
        return v[XW-1] ? -QW'(m) : QW'(m);
    endfunction

endpackage

`default_nettype wire

// ===== rtl/sdp_sqrt.sv =====
// Pipelined integer square root, one result bit per stage, with a sideband word.
`default_nettype none
`include "signed_distance_primitive_macros.svh"

module sdp_sqrt (
    input  wire logic                                  i_clk,
    input  wire logic                                  i_rst_n,
    input  wire sdp_pkg::t_pipe_ctl                    i_ctl,
    input  wire logic [sdp_pkg::RADW-1:0]              i_rad,
    input  wire logic signed [sdp_pkg::SUBW-1:0]       i_side,
    output logic                                       o_vld,
    output logic [sdp_pkg::ROOTW-1:0]                  o_root,
    output logic signed [sdp_pkg::SUBW-1:0]            o_side
);

    localparam int N = sdp_pkg::ROOTW;

    logic [sdp_pkg::REMW-1:0]        r_rem  [N];
    logic [sdp_pkg::ROOTW-1:0]       r_root [N];
    logic [sdp_pkg::RADW-1:0]        r_rad  [N];
    logic signed [sdp_pkg::SUBW-1:0] r_side [N];
    logic [N-1:0]                    r_vld;

    logic [sdp_pkg::REMW-1:0]        w_rem_in  [N];
    logic [sdp_pkg::ROOTW-1:0]       w_root_in [N];
    logic [sdp_pkg::RADW-1:0]        w_rad_in  [N];
    logic signed [sdp_pkg::SUBW-1:0] w_side_in [N];
    logic [N-1:0]                    w_vld_in;
    logic [sdp_pkg::REMW-1:0]        w_sh      [N];
    logic [sdp_pkg::REMW-1:0]        w_trial   [N];
    logic [sdp_pkg::REMW-1:0]        n_rem     [N];
    logic [sdp_pkg::ROOTW-1:0]       n_root    [N];

    always_comb begin
        w_rem_in[0]  = '0;
        w_root_in[0] = '0;
        w_rad_in[0]  = i_rad;
        w_side_in[0] = i_side;
        w_vld_in[0]  = i_ctl.vld;
        for (int j = 1; j < N; j++) begin
            w_rem_in[j]  = r_rem[j-1];
            w_root_in[j] = r_root[j-1];
            w_rad_in[j]  = r_rad[j-1];
            w_side_in[j] = r_side[j-1];
            w_vld_in[j]  = r_vld[j-1];
        end
    end

    always_comb begin
        for (int j = 0; j < N; j++) begin
            w_sh[j]    = {w_rem_in[j][sdp_pkg::REMW-3:0], w_rad_in[j][sdp_pkg::RADW-1 -: 2]};
            w_trial[j] = {1'b0, w_root_in[j], 2'b01};
            if (w_sh[j] >= w_trial[j]) begin
                n_rem[j]  = w_sh[j] - w_trial[j];
                n_root[j] = {w_root_in[j][sdp_pkg::ROOTW-2:0], 1'b1};
            end else begin
                n_rem[j]  = w_sh[j];
                n_root[j] = {w_root_in[j][sdp_pkg::ROOTW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (i_ctl.en) begin
            r_vld <= w_vld_in;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.en) begin
            for (int j = 0; j < N; j++) begin
                r_rem[j]  <= n_rem[j];
                r_root[j] <= n_root[j];
                r_rad[j]  <= w_rad_in[j] << 2;
                r_side[j] <= w_side_in[j];
            end
        end
    end

    assign o_vld  = r_vld[N-1];
    assign o_root = r_root[N-1];
    assign o_side = r_side[N-1];

    `SDP_ASSERT_NEXT(a_sqrt_hold, i_clk, i_rst_n, !i_ctl.en, $stable(o_vld) && $stable(o_root))
    `SDP_ASSERT_NEXT(a_sqrt_take, i_clk, i_rst_n, i_ctl.en && i_ctl.vld, r_vld[0])
    `SDP_ASSERT_NEXT(a_sqrt_bubble, i_clk, i_rst_n, i_ctl.en && !i_ctl.vld, !r_vld[0])

endmodule

`default_nettype wire

// ===== rtl/signed_distance_primitive.sv =====
// Top level of the signed distance primitive: register file and arithmetic pipeline.
//
//   channel   direction  handshake                          payload
//   in        to block   i_in_valid / o_in_stall            i_in_data  (t_in_item)
//   out       from block o_out_valid / i_out_stall          o_out_data (t_out_item)
//   cfg       to block   psel penable pwrite / pready       paddr pwdata, prdata
//
// One transfer per cycle in each direction unless the output stalls; the pipeline
// is the 41-stage square root plus 7 stages ahead of it and 3 after.
// A stalled output freezes every stage at once; nothing is dropped or repeated.
// Reset clears all valid bits and all configuration registers to zero.
`default_nettype none
`include "signed_distance_primitive_macros.svh"

module signed_distance_primitive (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_in_valid,
    output logic                             o_in_stall,
    input  wire sdp_pkg::t_in_item           i_in_data,
    output logic                             o_out_valid,
    input  wire logic                        i_out_stall,
    output sdp_pkg::t_out_item               o_out_data,
    input  wire logic                        psel,
    input  wire logic                        penable,
    input  wire logic                        pwrite,
    input  wire logic [sdp_pkg::PADDRW-1:0]  paddr,
    input  wire logic [63:0]                 pwdata,
    output logic [63:0]                      prdata,
    output logic                             pready
);

    logic [1:0]         r_mode;
    logic signed [31:0] r_cx, r_cy, r_cz;
    logic [47:0]        r_axis;
    logic signed [31:0] r_prm;
    logic [31:0]        r_norm;
    logic [2:0]         w_idx;

    assign pready = 1'b1;
    assign w_idx  = paddr[5:3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= '0;
            r_cx   <= '0;
            r_cy   <= '0;
            r_cz   <= '0;
            r_axis <= '0;
            r_prm  <= '0;
            r_norm <= '0;
        end else if (psel && penable && pwrite) begin
            unique case (w_idx)
                sdp_pkg::REG_SHAPE_MODE:  r_mode <= pwdata[1:0];
                sdp_pkg::REG_CENTER_X:    r_cx   <= pwdata[31:0];
                sdp_pkg::REG_CENTER_Y:    r_cy   <= pwdata[31:0];
                sdp_pkg::REG_CENTER_Z:    r_cz   <= pwdata[31:0];
                sdp_pkg::REG_AXIS_PACKED: r_axis <= pwdata[47:0];
                sdp_pkg::REG_SHAPE_PARAM: r_prm  <= pwdata[31:0];
                sdp_pkg::REG_NORM_FACTOR: r_norm <= pwdata[31:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            sdp_pkg::REG_SHAPE_MODE:  prdata = {62'd0, r_mode};
            sdp_pkg::REG_CENTER_X:    prdata = {32'd0, r_cx};
            sdp_pkg::REG_CENTER_Y:    prdata = {32'd0, r_cy};
            sdp_pkg::REG_CENTER_Z:    prdata = {32'd0, r_cz};
            sdp_pkg::REG_AXIS_PACKED: prdata = {16'd0, r_axis};
            sdp_pkg::REG_SHAPE_PARAM: prdata = {32'd0, r_prm};
            sdp_pkg::REG_NORM_FACTOR: prdata = {32'd0, r_norm};
            default:                  prdata = '0;
        endcase
    end

    logic signed [15:0] w_a [3];
    assign w_a[0] = r_axis[15:0];
    assign w_a[1] = r_axis[31:16];
    assign w_a[2] = r_axis[47:32];

    logic en;
    logic r_out_vld;
    assign en         = !(r_out_vld && i_out_stall);
    assign o_in_stall = !en;

    // stage A: offsets from the center
    logic                         r_a_vld;
    logic signed [31:0]           r_a_p [3];
    logic signed [sdp_pkg::DW-1:0] r_a_d [3];
    logic signed [31:0]           w_p [3];
    logic signed [31:0]           w_c [3];

    assign w_p[0] = sdp_pkg::coord_ext(i_in_data.pos_x);
    assign w_p[1] = sdp_pkg::coord_ext(i_in_data.pos_y);
    assign w_p[2] = sdp_pkg::coord_ext(i_in_data.pos_z);
    assign w_c[0] = sdp_pkg::coord_ext(r_cx);
    assign w_c[1] = sdp_pkg::coord_ext(r_cy);
    assign w_c[2] = sdp_pkg::coord_ext(r_cz);

    // stage B: axis products
    logic                          r_b_vld;
    logic signed [sdp_pkg::EW-1:0] r_b_e [3];
    logic signed [sdp_pkg::DW-1:0] r_b_d [3];

    // stage C: axial projection
    logic                            r_c_vld;
    logic signed [sdp_pkg::S16W-1:0] r_c_s16;
    logic signed [sdp_pkg::DW-1:0]   r_c_d [3];
    logic signed [sdp_pkg::SW-1:0]   w_s;

    assign w_s = sdp_pkg::SW'(r_b_e[0]) + sdp_pkg::SW'(r_b_e[1]) + sdp_pkg::SW'(r_b_e[2]);

    // stage D: projection back along the axis, cone slope product
    logic                            r_d_vld;
    logic signed [sdp_pkg::TW-1:0]   r_d_t [3];
    logic signed [sdp_pkg::DW-1:0]   r_d_d [3];
    logic signed [sdp_pkg::S16W-1:0] r_d_s16;
    logic [sdp_pkg::PRW-1:0]         r_d_pr;
    logic [sdp_pkg::S16W-1:0]        w_s16_mag;
    logic [31:0]                     w_prm_mag;

    assign w_s16_mag = r_c_s16[sdp_pkg::S16W-1] ? sdp_pkg::S16W'(-r_c_s16)
                                                 : sdp_pkg::S16W'(r_c_s16);
    assign w_prm_mag = r_prm[31] ? 32'(-r_prm) : 32'(r_prm);

    // stage E: perpendicular vector magnitudes and the subtrahend
    logic                            r_e_vld;
    logic [sdp_pkg::QW-1:0]          r_e_m [3];
    logic signed [sdp_pkg::SUBW-1:0] r_e_sub;
    logic signed [sdp_pkg::QW-1:0]   w_v [3];
    logic signed [sdp_pkg::SUBW-1:0] w_sub;
    logic [sdp_pkg::PRW-17:0]        w_cm;
    logic                            w_cneg;

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            if (r_mode == sdp_pkg::MODE_SPHERE) begin
                w_v[i] = sdp_pkg::QW'(r_d_d[i]);
            end else if (r_mode == sdp_pkg::MODE_PLANE) begin
                w_v[i] = '0;
            end else begin
                w_v[i] = sdp_pkg::shr14_x((sdp_pkg::XW'(r_d_d[i]) <<< 14)
                                          - sdp_pkg::XW'(r_d_t[i]));
            end
        end
    end

    assign w_cm   = r_d_pr[sdp_pkg::PRW-1:16];
    assign w_cneg = r_prm[31] != r_d_s16[sdp_pkg::S16W-1];

    always_comb begin
        case (r_mode)
            sdp_pkg::MODE_CONE:  w_sub = w_cneg ? -sdp_pkg::SUBW'(w_cm) : sdp_pkg::SUBW'(w_cm);
            sdp_pkg::MODE_PLANE: w_sub = sdp_pkg::SUBW'(r_prm) - sdp_pkg::SUBW'(r_d_s16);
            default:             w_sub = sdp_pkg::SUBW'(r_prm);
        endcase
    end

    // stage F: split squares
    logic                            r_f_vld;
    logic [2*sdp_pkg::HALFW-1:0]     r_f_hh [3];
    logic [2*sdp_pkg::HALFW-1:0]     r_f_hl [3];
    logic [2*sdp_pkg::HALFW-1:0]     r_f_ll [3];
    logic signed [sdp_pkg::SUBW-1:0] r_f_sub;

    // stage G: sum of squares
    logic                            r_g_vld;
    logic [sdp_pkg::RADW-1:0]        r_g_rad;
    logic signed [sdp_pkg::SUBW-1:0] r_g_sub;
    logic [sdp_pkg::RADW-1:0]        w_rad;

    always_comb begin
        w_rad = '0;
        for (int i = 0; i < 3; i++) begin
            w_rad = w_rad + (sdp_pkg::RADW'(r_f_hh[i]) << (2 * sdp_pkg::HALFW))
                          + (sdp_pkg::RADW'(r_f_hl[i]) << (sdp_pkg::HALFW + 1))
                          + sdp_pkg::RADW'(r_f_ll[i]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_vld <= 1'b0;
            r_b_vld <= 1'b0;
            r_c_vld <= 1'b0;
            r_d_vld <= 1'b0;
            r_e_vld <= 1'b0;
            r_f_vld <= 1'b0;
            r_g_vld <= 1'b0;
        end else if (en) begin
            r_a_vld <= i_in_valid;
            r_b_vld <= r_a_vld;
            r_c_vld <= r_b_vld;
            r_d_vld <= r_c_vld;
            r_e_vld <= r_d_vld;
            r_f_vld <= r_e_vld;
            r_g_vld <= r_f_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            for (int i = 0; i < 3; i++) begin
                r_a_p[i] <= w_p[i];
                r_a_d[i] <= sdp_pkg::DW'(w_p[i]) - sdp_pkg::DW'(w_c[i]);
                r_b_e[i] <= (r_mode == sdp_pkg::MODE_PLANE)
                            ? sdp_pkg::EW'(r_a_p[i]) * sdp_pkg::EW'(w_a[i])
                            : sdp_pkg::EW'(r_a_d[i]) * sdp_pkg::EW'(w_a[i]);
                r_b_d[i] <= r_a_d[i];
                r_c_d[i] <= r_b_d[i];
                r_d_d[i] <= r_c_d[i];
                r_d_t[i] <= sdp_pkg::TW'(r_c_s16) * sdp_pkg::TW'(w_a[i]);
                r_e_m[i] <= w_v[i][sdp_pkg::QW-1] ? sdp_pkg::QW'(-w_v[i]) : sdp_pkg::QW'(w_v[i]);
                r_f_hh[i] <= (2*sdp_pkg::HALFW)'(r_e_m[i][sdp_pkg::QW-1 -: sdp_pkg::HALFW])
                             * (2*sdp_pkg::HALFW)'(r_e_m[i][sdp_pkg::QW-1 -: sdp_pkg::HALFW]);
                r_f_hl[i] <= (2*sdp_pkg::HALFW)'(r_e_m[i][sdp_pkg::QW-1 -: sdp_pkg::HALFW])
                             * (2*sdp_pkg::HALFW)'(r_e_m[i][sdp_pkg::HALFW-1:0]);
                r_f_ll[i] <= (2*sdp_pkg::HALFW)'(r_e_m[i][sdp_pkg::HALFW-1:0])
                             * (2*sdp_pkg::HALFW)'(r_e_m[i][sdp_pkg::HALFW-1:0]);
            end
            r_c_s16 <= sdp_pkg::shr14_s(w_s);
            r_d_s16 <= r_c_s16;
            r_d_pr  <= sdp_pkg::PRW'(w_s16_mag) * sdp_pkg::PRW'(w_prm_mag);
            r_e_sub <= w_sub;
            r_f_sub <= r_e_sub;
            r_g_rad <= w_rad;
            r_g_sub <= r_f_sub;
        end
    end

    sdp_pkg::t_pipe_ctl              w_ctl;
    logic                            w_sq_vld;
    logic [sdp_pkg::ROOTW-1:0]       w_root;
    logic signed [sdp_pkg::SUBW-1:0] w_side;

    assign w_ctl.en  = en;
    assign w_ctl.vld = r_g_vld;

    sdp_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (w_ctl),
        .i_rad   (r_g_rad),
        .i_side  (r_g_sub),
        .o_vld   (w_sq_vld),
        .o_root  (w_root),
        .o_side  (w_side)
    );

    // stage H: raw distance
    logic                             r_h_vld;
    logic signed [sdp_pkg::DISTW-1:0] r_h_dist;

    // stage I: normalize product or saturate
    logic                     r_i_vld;
    logic                     r_i_norm;
    logic                     r_i_neg;
    logic [sdp_pkg::PRODW-1:0] r_i_prod;
    logic signed [31:0]       r_i_val;
    logic                     r_i_sat;
    logic [sdp_pkg::DISTW-1:0] w_md;
    logic [32:0]              w_md33;

    assign w_md   = r_h_dist[sdp_pkg::DISTW-1] ? sdp_pkg::DISTW'(-r_h_dist)
                                               : sdp_pkg::DISTW'(r_h_dist);
    assign w_md33 = (w_md > (sdp_pkg::DISTW'(1) << 32)) ? 33'h1_0000_0000 : w_md[32:0];

    // output stage
    logic                     r_out_norm;
    sdp_pkg::t_out_item       r_out;
    logic [sdp_pkg::PRODW-17:0] w_v16;
    logic [16:0]              w_vc;

    assign w_v16 = r_i_prod[sdp_pkg::PRODW-1:16];
    assign w_vc  = (w_v16 > (sdp_pkg::PRODW-16)'(65536)) ? 17'h10000 : w_v16[16:0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_h_vld   <= 1'b0;
            r_i_vld   <= 1'b0;
            r_out_vld <= 1'b0;
        end else if (en) begin
            r_h_vld   <= w_sq_vld;
            r_i_vld   <= r_h_vld;
            r_out_vld <= r_i_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_h_dist <= $signed(sdp_pkg::DISTW'(w_root)) - sdp_pkg::DISTW'(w_side);
            r_i_norm <= r_norm != 32'd0;
            r_i_neg  <= r_h_dist[sdp_pkg::DISTW-1];
            r_i_prod <= sdp_pkg::PRODW'(w_md33) * sdp_pkg::PRODW'(r_norm);
            if (r_h_dist > sdp_pkg::DISTW'(32'sh7fff_ffff)) begin
                r_i_val <= 32'sh7fff_ffff;
                r_i_sat <= 1'b1;
            end else if (r_h_dist < sdp_pkg::DISTW'(32'sh8000_0000)) begin
                r_i_val <= 32'sh8000_0000;
                r_i_sat <= 1'b1;
            end else begin
                r_i_val <= r_h_dist[31:0];
                r_i_sat <= 1'b0;
            end
            r_out_norm <= r_i_norm;
            if (r_i_norm) begin
                r_out.distance  <= r_i_neg ? -32'(w_vc) : 32'(w_vc);
                r_out.saturated <= 1'b0;
            end else begin
                r_out.distance  <= r_i_val;
                r_out.saturated <= r_i_sat;
            end
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_data  = r_out;

    logic w_norm_ok;
    assign w_norm_ok = (r_out.distance <= 32'sd65536) && (r_out.distance >= -32'sd65536);

    `SDP_ASSERT_IMPL(a_stall_back, i_clk, i_rst_n, r_out_vld && i_out_stall, o_in_stall)
    `SDP_ASSERT_IMPL(a_sat_raw, i_clk, i_rst_n, r_out_vld && r_out.saturated, !r_out_norm)
    `SDP_ASSERT_IMPL(a_norm_clamp, i_clk, i_rst_n, r_out_vld && r_out_norm, w_norm_ok)

endmodule

`default_nettype wire
